// File: hw/rtl/bcpe_pkg.sv
// Shared types, constants and knot helper for the B-spline curve evaluator.
package bcpe_pkg;

    localparam int MAX_POINTS_DEF  = 16;
    localparam int MAX_ORDER_DEF   = 4;
    localparam int MAX_DIMS_DEF    = 4;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 30;
    localparam int PADDR_W         = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LAST_INDEX = 2'd0;
    localparam logic [1:0] REG_ORDER      = 2'd1;
    localparam logic [1:0] REG_DIMS       = 2'd2;
    localparam logic [1:0] REG_COUNT      = 2'd3;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Configuration after range clamping
    typedef struct packed {
        logic [7:0]  n;       // last control index
        logic [7:0]  t;       // order
        logic [7:0]  rng;     // n - t + 2
        logic [3:0]  d;       // dimensions
        logic [15:0] cnt_m1;  // output count minus one
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_SETUP, S_VDIV, S_INIT,
        S_TA, S_DA, S_MA, S_AA,
        S_TB, S_DB, S_MB, S_AB,
        S_SH, S_SCLR, S_SUM, S_DR1, S_DR2, S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       wr;
        logic       latch_idx;
        logic       start_vdiv;
        logic       latch_v;
        logic       init_w;
        logic       init_end;
        logic       start_rdiv;
        logic       side;
        logic       mul;
        logic       add;
        logic       step;
        logic       sum_issue;
        logic       acc_clr;
        logic       emit;
        logic [7:0] k;
        logic [7:0] lvl;
        logic [3:0] j;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_end;
        logic div_busy;
        logic term_ok;
        logic live;
        logic out_free;
    } t_sts;

    // Integer knot j of the clamped uniform knot vector
    function automatic logic [7:0] knot_at(input logic [7:0] j, input logic [7:0] t,
                                           input logic [7:0] n, input logic [7:0] rng);
        logic [7:0] r;
        if (j < t) begin
            r = 8'd0;
        end else if (j <= n) begin
            r = j - t + 8'd1;
        end else begin
            r = rng;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bcpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bcpe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module bcpe_div #(
    parameter int DW = 48,
    parameter int SW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_div;
    logic [DW-1:0] r_quo;
    logic [SW:0]   trial;
    logic          qbit;
    logic [SW:0]   diff;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
    end

    // Control: count the bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    // Datapath: remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[SW-1:0] : trial[SW-1:0];
            r_quo <= {r_quo[DW-2:0], qbit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/bcpe_dp.sv
// Datapath: control store, parameter divide, basis recursion and weighted sum.
module bcpe_dp #(
    parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
    parameter int MAX_ORDER   = bcpe_pkg::MAX_ORDER_DEF,
    parameter int MAX_DIMS    = bcpe_pkg::MAX_DIMS_DEF,
    parameter int VALUE_WIDTH = bcpe_pkg::VALUE_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcpe_pkg::t_cmd  i_cmd,
    input  bcpe_pkg::t_cfg  i_cfg,
    input  logic [3:0]      i_point_index,
    input  logic [1:0]      i_coordinate_index,
    input  logic [31:0]     i_coordinate_value,
    input  logic [15:0]     i_output_index,
    input  logic            i_out_stall,
    output bcpe_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output logic [1:0]      o_result_dimension,
    output logic [31:0]     o_result_value,
    output logic            o_result_last
);

    localparam int FRAC  = bcpe_pkg::FRAC_BITS;
    localparam int L     = MAX_POINTS + MAX_ORDER;
    localparam int RW    = $clog2(MAX_POINTS + 1);
    localparam int VD    = RW + FRAC;
    localparam int XW    = 8 + FRAC;
    localparam int DVW   = 16 + RW + FRAC;
    localparam int DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [30:0] ONE = 31'd1 << FRAC;
    localparam logic signed [65:0] ACC_LIM = 66'sd1 <<< 62;
    localparam logic signed [65:0] RND     = 66'sd1 <<< (FRAC - 1);
    localparam logic signed [65:0] SAT_HI  = (66'sd1 <<< (VALUE_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO  = -SAT_HI - 66'sd1;

    logic [15:0]        r_idx;
    logic [VD-1:0]      r_v;
    logic [31:0]        r_w [L];
    logic [31:0]        r_sum;
    logic [62:0]        r_prod;
    logic [31:0]        r_w1;
    logic               r_v1;
    logic signed [64:0] r_p;
    logic               r_v2;
    logic signed [65:0] r_acc;
    logic               r_out_valid;
    logic [1:0]         r_dim;
    logic [31:0]        r_val;
    logic               r_last;

    logic [7:0]         kn_k, kn_k1, kn_ki1, kn_ki, s1, s2;
    logic [RW-1:0]      vint;
    logic [XW-1:0]      v_x, lo_x, hi_x;
    logic               ok_a, ok_b, live;
    logic [DVW-1:0]     div_a, div_q;
    logic [15:0]        div_b;
    logic               div_busy;
    logic [30:0]        ratio;
    logic [31:0]        wsel;
    logic [62:0]        prod_c;
    logic [31:0]        init_w [L];
    logic [15:0]        raddr_full, waddr_full;
    logic [AW-1:0]      raddr, waddr;
    logic               we;
    logic [31:0]        ram_q;
    logic signed [64:0] mul_c;
    logic signed [65:0] acc_sum, acc_rnd, q_val, sat_val;

    // Knots around the current recursion step
    always_comb begin
        kn_k   = bcpe_pkg::knot_at(i_cmd.k, i_cfg.t, i_cfg.n, i_cfg.rng);
        kn_k1  = bcpe_pkg::knot_at(i_cmd.k + 8'd1, i_cfg.t, i_cfg.n, i_cfg.rng);
        kn_ki1 = bcpe_pkg::knot_at(i_cmd.k + i_cmd.lvl - 8'd1, i_cfg.t, i_cfg.n, i_cfg.rng);
        kn_ki  = bcpe_pkg::knot_at(i_cmd.k + i_cmd.lvl, i_cfg.t, i_cfg.n, i_cfg.rng);
        s1     = kn_ki1 - kn_k;
        s2     = kn_ki - kn_k1;
        vint   = r_v[VD-1:FRAC];
        v_x    = XW'(r_v);
        lo_x   = {kn_k, {FRAC{1'b0}}};
        hi_x   = {kn_ki, {FRAC{1'b0}}};
        ok_a   = (s1 != 8'd0) && (r_w[0] != 32'd0) && (v_x >= lo_x);
        ok_b   = (s2 != 8'd0) && (r_w[1] != 32'd0) && (v_x <= hi_x);
        live   = ({1'b0, i_cmd.k} + {1'b0, i_cmd.lvl}) <= ({1'b0, i_cfg.n} + {1'b0, i_cfg.t});
    end

    // Divider operands: parameter divide or one ratio term
    always_comb begin
        if (i_cmd.start_vdiv) begin
            div_a = (DVW'(r_idx) * DVW'(i_cfg.rng[RW-1:0])) << FRAC;
            div_b = i_cfg.cnt_m1;
        end else if (i_cmd.side) begin
            div_a = DVW'(hi_x - v_x);
            div_b = 16'(s2);
        end else begin
            div_a = DVW'(v_x - lo_x);
            div_b = 16'(s1);
        end
    end

    bcpe_div #(
        .DW (DVW),
        .SW (16)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_vdiv | i_cmd.start_rdiv),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // Cap the ratio at one and weight it
    always_comb begin
        ratio  = (div_q > DVW'(ONE)) ? ONE : div_q[30:0];
        wsel   = i_cmd.side ? r_w[1] : r_w[0];
        prod_c = ratio * wsel;
    end

    // First-order weights: one on the span that holds the parameter
    always_comb begin
        for (int m = 0; m < L; m++) begin
            if ((8'(m) < i_cfg.n + i_cfg.t)
                && (bcpe_pkg::knot_at(8'(m), i_cfg.t, i_cfg.n, i_cfg.rng) <= 8'(vint))
                && (8'(vint) < bcpe_pkg::knot_at(8'(m + 1), i_cfg.t, i_cfg.n, i_cfg.rng)))
            begin
                init_w[m] = 32'(ONE);
            end else begin
                init_w[m] = 32'd0;
            end
        end
    end

    // Parameter, index and recursion registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_idx) begin
            r_idx <= i_output_index;
        end
        if (i_cmd.latch_v) begin
            r_v <= div_q[VD-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= prod_c;
        end
        priority if (i_cmd.init_w || i_cmd.init_end || i_cmd.step) begin
            r_sum <= 32'd0;
        end else if (i_cmd.add) begin
            r_sum <= r_sum + r_prod[FRAC+31:FRAC];
        end
        priority if (i_cmd.init_w) begin
            r_w <= init_w;
        end else if (i_cmd.init_end) begin
            for (int m = 0; m < L; m++) begin
                r_w[m] <= (8'(m) == i_cfg.n) ? 32'(ONE) : 32'd0;
            end
        end else if (i_cmd.step || i_cmd.sum_issue) begin
            for (int m = 0; m < L - 1; m++) begin
                r_w[m] <= r_w[m+1];
            end
            r_w[L-1] <= (i_cmd.step && live) ? r_sum : r_w[0];
        end
    end

    // Control store addressing
    always_comb begin
        waddr_full = 16'(i_point_index) * 16'(MAX_DIMS) + 16'(i_coordinate_index);
        waddr      = waddr_full[AW-1:0];
        we         = i_cmd.wr && (8'(i_point_index) < 8'(MAX_POINTS))
                     && (4'(i_coordinate_index) < 4'(MAX_DIMS));
        raddr_full = 16'(i_cmd.k) * 16'(MAX_DIMS) + 16'(i_cmd.j);
        raddr      = (i_cmd.k <= i_cfg.n) ? raddr_full[AW-1:0] : '0;
    end

    bcpe_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_coordinate_value),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // Multiply-accumulate with clamping, then round and saturate
    always_comb begin
        mul_c   = $signed(ram_q) * $signed({1'b0, r_w1});
        acc_sum = r_acc + 66'(r_p);
        acc_rnd = r_acc + RND;
        q_val   = acc_rnd >>> FRAC;
        if (q_val > SAT_HI) begin
            sat_val = SAT_HI;
        end else if (q_val < SAT_LO) begin
            sat_val = SAT_LO;
        end else begin
            sat_val = q_val;
        end
    end

    // Sum pipeline payload
    always_ff @(posedge i_clk) begin
        r_w1 <= r_w[0];
        r_p  <= mul_c;
        priority if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            if (acc_sum > ACC_LIM) begin
                r_acc <= ACC_LIM;
            end else if (acc_sum < -ACC_LIM) begin
                r_acc <= -ACC_LIM;
            end else begin
                r_acc <= acc_sum;
            end
        end
        if (i_cmd.emit) begin
            r_dim  <= i_cmd.j[1:0];
            r_val  <= sat_val[31:0];
            r_last <= (i_cmd.j == i_cfg.d - 4'd1);
        end
    end

    // Sum pipeline valid tags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sum_issue && (i_cmd.k <= i_cfg.n);
            r_v2 <= r_v1;
            priority if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_end   = (r_idx >= i_cfg.cnt_m1);
    assign o_sts.div_busy = div_busy;
    assign o_sts.term_ok  = i_cmd.side ? ok_b : ok_a;
    assign o_sts.live     = live;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_result_dimension = r_dim;
    assign o_result_value     = r_val;
    assign o_result_last      = r_last;

endmodule

// File: hw/rtl/bcpe_ctrl.sv
// Controller: sequences parameter divide, basis recursion and per-dimension sums.
module bcpe_ctrl #(
    parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF,
    parameter int MAX_ORDER  = bcpe_pkg::MAX_ORDER_DEF,
    parameter int MAX_DIMS   = bcpe_pkg::MAX_DIMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_operation,
    input  bcpe_pkg::t_cfg i_cfg,
    input  bcpe_pkg::t_sts i_sts,
    output bcpe_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);

    localparam int L  = MAX_POINTS + MAX_ORDER;
    localparam int KW = $clog2(L);
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int JW = $clog2(MAX_DIMS + 1);

    bcpe_pkg::t_state r_state, n_state;
    logic [KW-1:0]    r_k, n_k;
    logic [OW-1:0]    r_lvl, n_lvl;
    logic [JW-1:0]    r_j, n_j;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcpe_pkg::S_IDLE;
            r_k     <= '0;
            r_lvl   <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_lvl   <= n_lvl;
            r_j     <= n_j;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_lvl      = r_lvl;
        n_j        = r_j;
        o_cmd      = '0;
        o_cmd.k    = 8'(r_k);
        o_cmd.lvl  = 8'(r_lvl);
        o_cmd.j    = 4'(r_j);
        o_in_stall = 1'b1;
        unique case (r_state)
            bcpe_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_operation == bcpe_pkg::OP_LOAD) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.latch_idx = 1'b1;
                        n_state         = bcpe_pkg::S_SETUP;
                    end
                end
            end
            bcpe_pkg::S_SETUP: begin
                n_j = '0;
                if (i_sts.is_end) begin
                    o_cmd.init_end = 1'b1;
                    n_state        = bcpe_pkg::S_SCLR;
                end else begin
                    o_cmd.start_vdiv = 1'b1;
                    n_state          = bcpe_pkg::S_VDIV;
                end
            end
            bcpe_pkg::S_VDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.latch_v = 1'b1;
                    n_state       = bcpe_pkg::S_INIT;
                end
            end
            bcpe_pkg::S_INIT: begin
                o_cmd.init_w = 1'b1;
                n_k          = '0;
                n_lvl        = OW'(2);
                if (i_cfg.t < 8'd2) begin
                    n_state = bcpe_pkg::S_SCLR;
                end else begin
                    n_state = bcpe_pkg::S_TA;
                end
            end
            // Left term of one recursion step
            bcpe_pkg::S_TA: begin
                if (i_sts.live && i_sts.term_ok) begin
                    o_cmd.start_rdiv = 1'b1;
                    n_state          = bcpe_pkg::S_DA;
                end else begin
                    n_state = bcpe_pkg::S_TB;
                end
            end
            bcpe_pkg::S_DA: begin
                if (!i_sts.div_busy) begin
                    n_state = bcpe_pkg::S_MA;
                end
            end
            bcpe_pkg::S_MA: begin
                o_cmd.mul = 1'b1;
                n_state   = bcpe_pkg::S_AA;
            end
            bcpe_pkg::S_AA: begin
                o_cmd.add = 1'b1;
                n_state   = bcpe_pkg::S_TB;
            end
            // Right term of one recursion step
            bcpe_pkg::S_TB: begin
                o_cmd.side = 1'b1;
                if (i_sts.live && i_sts.term_ok) begin
                    o_cmd.start_rdiv = 1'b1;
                    n_state          = bcpe_pkg::S_DB;
                end else begin
                    n_state = bcpe_pkg::S_SH;
                end
            end
            bcpe_pkg::S_DB: begin
                o_cmd.side = 1'b1;
                if (!i_sts.div_busy) begin
                    n_state = bcpe_pkg::S_MB;
                end
            end
            bcpe_pkg::S_MB: begin
                o_cmd.side = 1'b1;
                o_cmd.mul  = 1'b1;
                n_state    = bcpe_pkg::S_AB;
            end
            bcpe_pkg::S_AB: begin
                o_cmd.side = 1'b1;
                o_cmd.add  = 1'b1;
                n_state    = bcpe_pkg::S_SH;
            end
            // Store the new weight and rotate the weight line
            bcpe_pkg::S_SH: begin
                o_cmd.step = 1'b1;
                if (r_k == KW'(L - 1)) begin
                    n_k = '0;
                    if (8'(r_lvl) >= i_cfg.t) begin
                        n_state = bcpe_pkg::S_SCLR;
                    end else begin
                        n_lvl   = r_lvl + OW'(1);
                        n_state = bcpe_pkg::S_TA;
                    end
                end else begin
                    n_k     = r_k + KW'(1);
                    n_state = bcpe_pkg::S_TA;
                end
            end
            bcpe_pkg::S_SCLR: begin
                o_cmd.acc_clr = 1'b1;
                n_k           = '0;
                n_state       = bcpe_pkg::S_SUM;
            end
            bcpe_pkg::S_SUM: begin
                o_cmd.sum_issue = 1'b1;
                if (r_k == KW'(L - 1)) begin
                    n_k     = '0;
                    n_state = bcpe_pkg::S_DR1;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            bcpe_pkg::S_DR1: begin
                n_state = bcpe_pkg::S_DR2;
            end
            bcpe_pkg::S_DR2: begin
                n_state = bcpe_pkg::S_EMIT;
            end
            bcpe_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (4'(r_j) == i_cfg.d - 4'd1) begin
                        n_state = bcpe_pkg::S_IDLE;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = bcpe_pkg::S_SCLR;
                    end
                end
            end
            default: begin
                n_state = bcpe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/bspline_curve_point_evaluator_top.sv
// Top level of the clamped uniform B-spline curve point evaluator.
//
// Input channel (i_in_valid / o_in_stall): a load transfer writes one Q16.16
// control coordinate. An evaluate transfer computes one
// curve point and yields one output transfer per dimension, in ascending
// dimension order, with o_result_last on the highest one.
// Configuration goes through the APB-style port, four registers read back as
// 32-bit words at byte addresses 0, 4, 8 and 12; pready is always high.
// An evaluate first divides for the curve parameter on the bit-serial divider
// of width W = 16 + clog2(MAX_POINTS+1) + 30, then runs L*(order-1)
// recursion steps (L = MAX_POINTS + MAX_ORDER) with one divide for every
// nonzero ratio term, then a multiply-accumulate over the control store for
// each dimension. The divider is shared between the parameter and the ratio
// terms, and the store has a single read port.
// The final output index skips the recursion.
// Only one evaluate is in flight; o_in_stall is high until its last result
// has been placed in the output register.
// A stalled output holds its value; the block waits before writing the
// next result. Reset returns the registers to their defaults and drops
// any pending result; the control store keeps its contents.
module bspline_curve_point_evaluator_top #(
    parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
    parameter int MAX_ORDER   = bcpe_pkg::MAX_ORDER_DEF,
    parameter int MAX_DIMS    = bcpe_pkg::MAX_DIMS_DEF,
    parameter int VALUE_WIDTH = bcpe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [3:0]                   i_point_index,
    input  logic [1:0]                   i_coordinate_index,
    input  logic [31:0]                  i_coordinate_value,
    input  logic [15:0]                  i_output_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_result_dimension,
    output logic [31:0]                  o_result_value,
    output logic                         o_result_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcpe_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [3:0]     r_last_index;
    logic [2:0]     r_order;
    logic [2:0]     r_dims;
    logic [15:0]    r_count;
    logic [1:0]     reg_sel;
    logic           cfg_wr;
    logic [7:0]     n_c, t_c;
    bcpe_pkg::t_cfg cfg;
    bcpe_pkg::t_cmd cmd;
    bcpe_pkg::t_sts sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= 4'd3;
            r_order      <= 3'd4;
            r_dims       <= 3'd3;
            r_count      <= 16'd16;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                bcpe_pkg::REG_LAST_INDEX: r_last_index <= pwdata[3:0];
                bcpe_pkg::REG_ORDER:      r_order      <= pwdata[2:0];
                bcpe_pkg::REG_DIMS:       r_dims       <= pwdata[2:0];
                bcpe_pkg::REG_COUNT:      r_count      <= pwdata[15:0];
                default:                  r_count      <= r_count;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_sel)
            bcpe_pkg::REG_LAST_INDEX: prdata = 32'(r_last_index);
            bcpe_pkg::REG_ORDER:      prdata = 32'(r_order);
            bcpe_pkg::REG_DIMS:       prdata = 32'(r_dims);
            bcpe_pkg::REG_COUNT:      prdata = 32'(r_count);
            default:                  prdata = 32'd0;
        endcase
    end

    // Clamp the configuration into its working range
    always_comb begin
        n_c = 8'(r_last_index);
        if (n_c > 8'(MAX_POINTS - 1)) begin
            n_c = 8'(MAX_POINTS - 1);
        end
        if (n_c < 8'd1) begin
            n_c = 8'd1;
        end
        t_c = 8'(r_order);
        if (t_c < 8'd1) begin
            t_c = 8'd1;
        end
        if (t_c > 8'(MAX_ORDER)) begin
            t_c = 8'(MAX_ORDER);
        end
        if (t_c > n_c + 8'd1) begin
            t_c = n_c + 8'd1;
        end
        cfg.n   = n_c;
        cfg.t   = t_c;
        cfg.rng = n_c - t_c + 8'd2;
        if (r_dims == 3'd0) begin
            cfg.d = 4'd1;
        end else if (4'(r_dims) > 4'(MAX_DIMS)) begin
            cfg.d = 4'(MAX_DIMS);
        end else begin
            cfg.d = 4'(r_dims);
        end
        cfg.cnt_m1 = (r_count < 16'd2) ? 16'd1 : r_count - 16'd1;
    end

    bcpe_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_ORDER  (MAX_ORDER),
        .MAX_DIMS   (MAX_DIMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_cfg       (cfg),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    bcpe_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_ORDER   (MAX_ORDER),
        .MAX_DIMS    (MAX_DIMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg              (cfg),
        .i_point_index      (i_point_index),
        .i_coordinate_index (i_coordinate_index),
        .i_coordinate_value (i_coordinate_value),
        .i_output_index     (i_output_index),
        .i_out_stall        (i_out_stall),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_result_dimension (o_result_dimension),
        .o_result_value     (o_result_value),
        .o_result_last      (o_result_last)
    );

endmodule

// File: hw/rtl/bcpe_chk.sv
// Port-level checker for the curve evaluator, bound to the top level.
module bcpe_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_operation,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result_value
);

    // Held output stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // Held output keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result_value))
        else $error("output value changed while stalled");

    // An evaluate transfer blocks the input
    a_eval_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation |=> o_in_stall)
        else $error("input not stalled after an evaluate");

    // A load transfer leaves the input open
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_operation |=> !o_in_stall)
        else $error("input stalled after a load");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind bspline_curve_point_evaluator_top bcpe_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_operation    (i_operation),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value)
);
